// ===== hw/rtl/aswp_pkg.sv =====
package aswp_pkg;

  // Sizing defaults
  localparam int unsigned DefaultStackDepth = 64;
  localparam int unsigned CapWidth          = 7;
  localparam int unsigned WordWidth         = 32;
  localparam logic [CapWidth-1:0] CapReset  = CapWidth'(64);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BADPOS    = 2'd3
  } status_e;

  // One-hot controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    op_e                         operation;
    logic signed [WordWidth-1:0] push_value;
    logic [CapWidth-1:0]         peek_depth;
  } in_item_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] read_value;
    status_e                     status;
    logic                        is_empty;
    logic                        is_full;
    logic signed [WordWidth-1:0] top_value;
    logic signed [WordWidth-1:0] bottom_value;
    logic [CapWidth-1:0]         entry_count;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // perform the step and load the result register
    logic finish;  // patch the result with the memory read data
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_read;  // offered transaction needs a memory read
  } dp_status_t;

endpackage

// ===== hw/rtl/aswp_ctrl.sv =====
module aswp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_ready_i,
  input  aswp_pkg::dp_status_t   status_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output aswp_pkg::ctrl_cmd_t    cmd_o
);

  aswp_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o = (state_q == aswp_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.accept = accept;
  assign cmd_o.finish = (state_q == aswp_pkg::ST_WAIT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aswp_pkg::ST_IDLE: begin
        if (accept && status_i.need_read) begin
          state_d = aswp_pkg::ST_WAIT;
        end
      end
      aswp_pkg::ST_WAIT: begin
        state_d = aswp_pkg::ST_IDLE;
      end
      default: begin
        state_d = aswp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((accept && !status_i.need_read) || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aswp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/aswp_datapath.sv =====
module aswp_datapath #(
  parameter int unsigned STACK_DEPTH = aswp_pkg::DefaultStackDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aswp_pkg::ctrl_cmd_t               cmd_i,
  input  aswp_pkg::in_item_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [aswp_pkg::CapWidth-1:0]     cfg_wdata_i,
  output aswp_pkg::dp_status_t              status_o,
  output aswp_pkg::out_item_t               out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = (CW > aswp_pkg::CapWidth) ? CW : aswp_pkg::CapWidth;
  localparam int unsigned WW = aswp_pkg::WordWidth;

  logic signed [WW-1:0] mem [STACK_DEPTH];
  logic signed [WW-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        waddr, raddr;

  logic [CW-1:0]                 count_q, count_d;
  logic [aswp_pkg::CapWidth-1:0] cap_q;
  logic signed [WW-1:0]          top_q, top_d, bottom_q, bottom_d;
  aswp_pkg::op_e                 pend_op_q;
  aswp_pkg::out_item_t           res_q, res_d;

  logic [EW-1:0] cnt_e, cap_e, depth_e, peek_e, cap_eff, cnt_new, raddr_e;
  logic          push_ok, pop_ok, peek_ok;

  assign cnt_e   = EW'(count_q);
  assign cap_e   = EW'(cap_q);
  assign depth_e = EW'(STACK_DEPTH);
  assign peek_e  = EW'(in_data_i.peek_depth);

  always_comb begin
    if (cap_e == '0) begin
      cap_eff = EW'(1);
    end else if (cap_e > depth_e) begin
      cap_eff = depth_e;
    end else begin
      cap_eff = cap_e;
    end
  end

  assign push_ok = (in_data_i.operation == aswp_pkg::OP_PUSH) && (cnt_e < cap_eff);
  assign pop_ok  = (in_data_i.operation == aswp_pkg::OP_POP) && (cnt_e != '0);
  assign peek_ok = (in_data_i.operation == aswp_pkg::OP_PEEK) && (peek_e != '0)
                   && (peek_e <= cnt_e);

  // Pop reads the entry below the old top; peek reads at count - depth
  assign status_o.need_read = (pop_ok && (cnt_e >= EW'(2))) || peek_ok;
  assign raddr_e = pop_ok ? (cnt_e - EW'(2)) : (cnt_e - peek_e);
  assign raddr   = raddr_e[AW-1:0];
  assign waddr   = count_q[AW-1:0];
  assign mem_we  = cmd_i.accept && push_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_data_i.push_value;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    cnt_new  = cnt_e;
    top_d    = top_q;
    bottom_d = bottom_q;
    res_d    = res_q;

    res_d.read_value = '0;
    res_d.status     = aswp_pkg::STAT_OK;

    case (in_data_i.operation)
      aswp_pkg::OP_PUSH: begin
        if (push_ok) begin
          cnt_new = cnt_e + EW'(1);
          top_d   = in_data_i.push_value;
          if (cnt_e == '0) begin
            bottom_d = in_data_i.push_value;
          end
        end else begin
          res_d.status = aswp_pkg::STAT_OVERFLOW;
        end
      end
      aswp_pkg::OP_POP: begin
        if (pop_ok) begin
          cnt_new          = cnt_e - EW'(1);
          res_d.read_value = top_q;
        end else begin
          res_d.status = aswp_pkg::STAT_UNDERFLOW;
        end
      end
      aswp_pkg::OP_PEEK: begin
        if (!peek_ok) begin
          res_d.status = aswp_pkg::STAT_BADPOS;
        end
      end
      default: begin
      end
    endcase

    res_d.is_empty     = (cnt_new == '0);
    res_d.is_full      = (cnt_new >= cap_eff);
    res_d.top_value    = (cnt_new == '0) ? '0 : top_d;
    res_d.bottom_value = (cnt_new == '0) ? '0 : bottom_d;
    res_d.entry_count  = cnt_new[aswp_pkg::CapWidth-1:0];
  end

  assign count_d = cnt_new[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cap_q     <= aswp_pkg::CapReset;
      pend_op_q <= aswp_pkg::OP_QUERY;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        count_q   <= count_d;
        pend_op_q <= in_data_i.operation;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      top_q    <= top_d;
      bottom_q <= bottom_d;
      res_q    <= res_d;
    end else if (cmd_i.finish) begin
      if (pend_op_q == aswp_pkg::OP_POP) begin
        top_q           <= rdata_q;
        res_q.top_value <= rdata_q;
      end else begin
        res_q.read_value <= rdata_q;
      end
    end
  end

  assign out_data_o = res_q;

endmodule

// ===== hw/rtl/array_stack_with_peek_top.sv =====
// LIFO stack of signed 32-bit words with push, pop, peek-at-depth and query.
// Input channel in_valid_i/in_ready_o carries one command per transaction;
// output channel out_valid_o/out_ready_i returns exactly one result for each.
// cfg_we_i/cfg_wdata_i write the active capacity (0 acts as 1, values above
// STACK_DEPTH act as STACK_DEPTH); write only while the block is idle.
// Push, query and refused commands give their result in the cycle after
// acceptance; a pop that leaves entries behind and a good peek also pass the
// read-wait state, set by the single registered read port of the entry memory.
// Push and query take one transaction per cycle while results are taken; a
// read takes no new command while waiting. A new command is taken in the cycle
// the held result is taken. Reset empties the stack (count 0) and sets the
// capacity to 64; memory contents are not cleared and are never read before
// being written. A stalled receiver holds the result in the output register
// and in_ready_o stays low until it is taken; nothing is dropped.
module array_stack_with_peek_top #(
  parameter int unsigned STACK_DEPTH = aswp_pkg::DefaultStackDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aswp_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aswp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [aswp_pkg::CapWidth-1:0] cfg_wdata_i
);

  aswp_pkg::ctrl_cmd_t  cmd;
  aswp_pkg::dp_status_t dp_status;

  // Sequencer: owns handshakes and the read-wait state
  aswp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Entry memory, count, cached top/bottom and result register
  aswp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (dp_status),
    .out_data_o  (out_data_o)
  );

  // Ready only when the result register is free or being emptied
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input taken while result register blocked");

  // Empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.entry_count == '0)))
    else $error("empty flag and count disagree");

  // An empty stack shows zero top and bottom
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_empty) |->
      (out_data_o.top_value == '0 && out_data_o.bottom_value == '0))
    else $error("empty stack shows nonzero top or bottom");

  // Overflow only reported on a full stack
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == aswp_pkg::STAT_OVERFLOW) |-> out_data_o.is_full)
    else $error("overflow reported while not full");

endmodule
